// File: rtl/cbmq_pkg.sv
`default_nettype none
package cbmq_pkg;
  localparam int unsigned NumBins = 256;
  localparam int unsigned BinBits = 30;
  localparam int unsigned BinIdxW = $clog2(NumBins);
  localparam int unsigned BitIdxW = $clog2(BinBits);
  localparam int unsigned CoordW = 31;
  localparam int unsigned WidthW = 16;
  localparam int unsigned QuoW = CoordW;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] RegOrigin = 1'b0;
  localparam logic [CfgIdxW-1:0] RegWidth = 1'b1;

  localparam logic CmdMark = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // Ranges of bins and bit masks that one command applies, passed cell to cell along the row.
  typedef struct packed {
    logic                active;
    logic                cmd;
    logic [BinIdxW-1:0]  bin_first;
    logic [BinIdxW-1:0]  bin_last;
    logic [BinBits-1:0]  mask_first;
    logic [BinBits-1:0]  mask_last;
  } op_t;
endpackage
`default_nettype wire

// File: rtl/cbmq_divider.sv
`default_nettype none
module cbmq_divider (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire [cbmq_pkg::CoordW-1:0]   dividend_i,
  input  wire [cbmq_pkg::CoordW+4:0]   divisor_i,
  output logic                         done_o,
  output logic [cbmq_pkg::QuoW-1:0]    quo_o,
  output logic [cbmq_pkg::CoordW-1:0]  rem_o
);
  localparam int unsigned CntW = $clog2(cbmq_pkg::CoordW + 1);

  logic [cbmq_pkg::CoordW+5:0] rem_q, rem_d, trial;
  logic [cbmq_pkg::CoordW-1:0] quo_q, quo_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    trial = {rem_q[cbmq_pkg::CoordW+4:0], quo_q[cbmq_pkg::CoordW-1]};
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = CntW'(cbmq_pkg::CoordW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = trial - {1'b0, divisor_i};
        quo_d = {quo_q[cbmq_pkg::CoordW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[cbmq_pkg::CoordW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quo_o = quo_d;
  assign rem_o = rem_d[cbmq_pkg::CoordW-1:0];
endmodule
`default_nettype wire

// File: rtl/cbmq_cell.sv
`default_nettype none
module cbmq_cell (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire [cbmq_pkg::BinIdxW-1:0]  bin_idx_i,
  input  wire cbmq_pkg::op_t           op_i,
  input  wire                          all_set_i,
  output cbmq_pkg::op_t                op_o,
  output logic                         all_set_o
);
  logic [cbmq_pkg::BinBits-1:0] word_q, word_d, need;
  logic hit;
  cbmq_pkg::op_t op_q;
  logic all_q;

  always_comb begin
    hit = op_i.active && (bin_idx_i >= op_i.bin_first) && (bin_idx_i <= op_i.bin_last);
    need = '1;
    if (bin_idx_i == op_i.bin_first) need = need & op_i.mask_first;
    if (bin_idx_i == op_i.bin_last) need = need & op_i.mask_last;
    word_d = word_q;
    if (hit && op_i.cmd == cbmq_pkg::CmdMark) word_d = word_q | need;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      op_q <= '0;
      all_q <= 1'b1;
    end else begin
      word_q <= word_d;
      op_q <= op_i;
      all_q <= all_set_i && (!hit || ((word_q & need) == need));
    end
  end

  assign op_o = op_q;
  assign all_set_o = all_q;
endmodule
`default_nettype wire

// File: rtl/coverage_bitmap_mark_query_top.sv
// Coverage map over 256 bins of 30 sub-bins, all clear after reset.
// Input channel: in_valid_i / in_stall_o with command_i, range_first_i and
// range_last_i. command 0 marks the range, command 1 asks whether the whole
// range is marked. Each transaction yields one result on the output channel
// out_valid_o / out_stall_i with fully_marked_o and in_range_o.
// Configuration: cfg_valid_i / cfg_ready_o, cfg_index_i 0 = origin,
// 1 = sub-bin width (0 acts as 1). Write only while idle.
// Each transaction runs two 31-step restoring divisions (one per
// coordinate), finds the two sub-bit positions, sends the command down a
// row of 256 cells and then loads the output register. One item is in
// flight at a time, so a new transaction is accepted only once the last
// one has left the cell row and its result is in the output register.
// The result sits in an output register; the next transaction is accepted
// while it waits, but its result waits until the old one has been taken.
// Reset clears all bins and sets origin 0 and width 100.
`default_nettype none
module coverage_bitmap_mark_query_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire                          command_i,
  input  wire [cbmq_pkg::CoordW-1:0]   range_first_i,
  input  wire [cbmq_pkg::CoordW-1:0]   range_last_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         fully_marked_o,
  output logic                         in_range_o,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [cbmq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire [cbmq_pkg::CoordW-1:0]   cfg_data_i
);
  localparam int unsigned N = cbmq_pkg::NumBins;
  localparam int unsigned CntW = $clog2(N + 2);

  typedef enum logic [2:0] {
    StIdle, StDivA, StDivB, StBits, StRow, StOut
  } state_e;

  state_e state_q;
  logic [cbmq_pkg::CoordW-1:0] origin_q;
  logic [cbmq_pkg::WidthW-1:0] width_q;
  logic cmd_q;
  logic [cbmq_pkg::CoordW-1:0] first_q, last_q;
  logic ok1_q, ok2_q;
  logic [cbmq_pkg::QuoW-1:0] b1_q, b2_q;
  logic [cbmq_pkg::CoordW-1:0] r1_q, r2_q;
  logic [cbmq_pkg::BitIdxW-1:0] t1_q, t2_q;
  logic [CntW-1:0] cnt_q;
  logic go_q, go_d;
  logic row_all_q;
  logic out_valid_q, full_q, inr_q;

  logic [cbmq_pkg::WidthW-1:0] w_eff;
  logic [cbmq_pkg::CoordW+4:0] span;
  logic div_start, div_done;
  logic [cbmq_pkg::CoordW-1:0] div_num, div_rem;
  logic [cbmq_pkg::QuoW-1:0] div_quo;
  logic accept;

  assign w_eff = (width_q == '0) ? cbmq_pkg::WidthW'(1) : width_q;
  assign span = (cbmq_pkg::CoordW+5)'(w_eff) * (cbmq_pkg::CoordW+5)'(cbmq_pkg::BinBits);
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle);

  assign div_start = go_q;
  assign div_num = (state_q == StDivA) ? first_q - origin_q : last_q - origin_q;

  cbmq_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_num), .divisor_i(span),
    .done_o(div_done), .quo_o(div_quo), .rem_o(div_rem)
  );

  // Bit index: remainder below 30*width, so the quotient by width is at most 29,
  // found by a short compare chain done one step per cycle.
  logic [cbmq_pkg::CoordW-1:0] bit_rem_q;
  logic bit_sel_q;

  assign go_d = accept || ((state_q == StDivA) && div_done) ||
                ((state_q == StBits) && bit_sel_q && (bit_rem_q < cbmq_pkg::CoordW'(w_eff)));

  cbmq_pkg::op_t op_chain [N+1];
  logic all_chain [N+1];
  logic in_bins;
  logic valid_rng;

  assign in_bins = ok1_q && ok2_q && (b1_q < cbmq_pkg::QuoW'(N)) &&
                   (b2_q < cbmq_pkg::QuoW'(N));
  assign valid_rng = in_bins && (first_q <= last_q);

  always_comb begin
    op_chain[0].active = go_q && (state_q == StRow) && valid_rng;
    op_chain[0].cmd = cmd_q;
    op_chain[0].bin_first = b1_q[cbmq_pkg::BinIdxW-1:0];
    op_chain[0].bin_last = b2_q[cbmq_pkg::BinIdxW-1:0];
    op_chain[0].mask_first = ~((cbmq_pkg::BinBits)'(1) << t1_q) + 1'b1;
    op_chain[0].mask_last = ((cbmq_pkg::BinBits)'(2) << t2_q) - 1'b1;
    all_chain[0] = 1'b1;
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    cbmq_cell u_cell (
      .clk_i, .rst_ni, .bin_idx_i(cbmq_pkg::BinIdxW'(g)), .op_i(op_chain[g]),
      .all_set_i(all_chain[g]), .op_o(op_chain[g+1]), .all_set_o(all_chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      origin_q <= '0;
      width_q <= cbmq_pkg::WidthW'(100);
      go_q <= 1'b0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
      bit_sel_q <= 1'b0;
    end else begin
      go_q <= go_d;
      if (state_q == StOut && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          cbmq_pkg::RegOrigin: origin_q <= cfg_data_i;
          cbmq_pkg::RegWidth: width_q <= cfg_data_i[cbmq_pkg::WidthW-1:0];
          default: ;
        endcase
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            cmd_q <= command_i;
            first_q <= range_first_i;
            last_q <= range_last_i;
            ok1_q <= range_first_i >= origin_q;
            ok2_q <= range_last_i >= origin_q;
            state_q <= StDivA;
          end
        end
        StDivA: begin
          if (div_done) begin
            b1_q <= div_quo;
            r1_q <= div_rem;
            state_q <= StDivB;
          end
        end
        StDivB: begin
          if (div_done) begin
            b2_q <= div_quo;
            r2_q <= div_rem;
            t1_q <= '0;
            t2_q <= '0;
            bit_sel_q <= 1'b0;
            bit_rem_q <= r1_q;
            state_q <= StBits;
          end
        end
        StBits: begin
          if (bit_rem_q >= cbmq_pkg::CoordW'(w_eff)) begin
            bit_rem_q <= bit_rem_q - cbmq_pkg::CoordW'(w_eff);
            if (bit_sel_q) t2_q <= t2_q + 1'b1;
            else t1_q <= t1_q + 1'b1;
          end else if (!bit_sel_q) begin
            bit_sel_q <= 1'b1;
            bit_rem_q <= r2_q;
          end else begin
            cnt_q <= '0;
            state_q <= StRow;
          end
        end
        StRow: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(N)) begin
            row_all_q <= all_chain[N];
            state_q <= StOut;
          end
        end
        StOut: begin
          if (!out_valid_q || !out_stall_i) begin
            inr_q <= in_bins;
            full_q <= (cmd_q == cbmq_pkg::CmdQuery) && valid_rng && row_all_q;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign fully_marked_o = full_q;
  assign in_range_o = inr_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q)
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == StDivA)
    else $error("accepted item not started");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> state_q == StIdle)
    else $error("config taken while busy");
endmodule
`default_nettype wire

// File: tb/coverage_bitmap_mark_query_top_tb.sv
module coverage_bitmap_mark_query_top_tb;
  import cbmq_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam longint CoordMax = 64'h7FFF_FFFF;

  typedef struct {
    logic cmd;
    logic [CoordW-1:0] first;
    logic [CoordW-1:0] last;
    bit has_exp;
    logic exp_full;
    logic exp_inr;
  } stim_row_t;

  typedef struct {
    logic full;
    logic inr;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic command_i = CmdMark;
  logic [CoordW-1:0] range_first_i = '0;
  logic [CoordW-1:0] range_last_i = '0;
  logic out_stall_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = RegOrigin;
  logic [CoordW-1:0] cfg_data_i = '0;
  logic in_stall_o, out_valid_o, fully_marked_o, in_range_o, cfg_ready_o;

  coverage_bitmap_mark_query_top DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i, .range_first_i,
    .range_last_i, .out_valid_o, .out_stall_i, .fully_marked_o, .in_range_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [BinBits-1:0] cov_bins [NumBins];
  longint origin_reg = 0;
  longint width_reg = 100;
  answer_t answer_q[$];
  bit row_has_exp = 1'b0;
  logic row_exp_full, row_exp_inr;
  int unsigned cycle_count = 0;
  int mismatches = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  function automatic bit locate_coord(input longint c, output int b, output int t);
    longint w, span, off;
    w = (width_reg == 0) ? 1 : width_reg;
    span = w * BinBits;
    if (c < origin_reg) return 1'b0;
    off = c - origin_reg;
    if (off / span >= NumBins) return 1'b0;
    b = int'(off / span);
    t = int'((off % span) / w);
    return 1'b1;
  endfunction

  function automatic answer_t apply_command(input logic cmd, input longint first,
                                            input longint last);
    answer_t a;
    int b1, b2, t1, t2;
    bit ok1, ok2;
    logic [BinBits-1:0] m1, m2, ones;
    ones = '1;
    ok1 = locate_coord(first, b1, t1);
    ok2 = locate_coord(last, b2, t2);
    a.inr = ok1 && ok2;
    a.full = 1'b0;
    if (a.inr && first <= last) begin
      m1 = ones << t1;
      m2 = ones >> (BinBits - 1 - t2);
      if (b1 == b2) begin
        m1 = m1 & m2;
      end
      if (cmd == CmdMark) begin
        cov_bins[b1] |= m1;
        for (int i = b1 + 1; i < b2; i++) cov_bins[i] = ones;
        if (b2 != b1) cov_bins[b2] |= m2;
      end else begin
        a.full = ((cov_bins[b1] & m1) == m1);
        for (int i = b1 + 1; i < b2; i++) if (cov_bins[i] != ones) a.full = 1'b0;
        if (b2 != b1 && (cov_bins[b2] & m2) != m2) a.full = 1'b0;
      end
    end
    return a;
  endfunction

  always @(posedge clk_i) begin
    answer_t a, e;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (in_valid_i && !in_stall_o) begin
      a = apply_command(command_i, range_first_i, range_last_i);
      if (row_has_exp) begin
        a.full = row_exp_full;
        a.inr = row_exp_inr;
      end
      answer_q.push_back(a);
    end
    if (out_valid_o && !out_stall_i) begin
      if (answer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction");
      end else begin
        e = answer_q.pop_front();
        if (fully_marked_o !== e.full || in_range_o !== e.inr) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected full=%0b inr=%0b, got full=%0b inr=%0b",
                     e.full, e.inr, fully_marked_o, in_range_o);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_item(input stim_row_t r);
    if (!quiet && $urandom_range(0, 9) < 3) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= r.cmd;
    range_first_i <= r.first;
    range_last_i <= r.last;
    row_has_exp <= r.has_exp;
    row_exp_full <= r.exp_full;
    row_exp_inr <= r.exp_inr;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input longint value);
    in_valid_i <= 1'b0;
    wait (answer_q.size() == 0);
    repeat (8) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[CoordW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == RegOrigin) origin_reg = value & CoordMax;
    else width_reg = value & 64'hFFFF;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic longint pick_coord();
    longint w, hi;
    w = (width_reg == 0) ? 1 : width_reg;
    hi = origin_reg + w * BinBits * NumBins + 2 * w;
    if (hi > CoordMax) hi = CoordMax;
    return origin_reg + $urandom_range(0, int'(hi - origin_reg));
  endfunction

  task automatic run_random(input int count);
    stim_row_t r;
    longint w, f, l, mf, ml;
    int sel;
    bit have_mark;
    have_mark = 1'b0;
    w = (width_reg == 0) ? 1 : width_reg;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      r.has_exp = 1'b0;
      r.exp_full = 1'b0;
      r.exp_inr = 1'b0;
      r.cmd = (sel < 70) ? CmdMark : CmdQuery;
      if (sel < 8) begin
        f = $urandom & CoordMax;
        l = $urandom & CoordMax;
        r.cmd = 1'($urandom_range(0, 1));
      end else if (sel < 13) begin
        l = pick_coord();
        f = l + 1 + $urandom_range(0, int'(w * 4));
      end else if (sel < 45 && have_mark) begin
        r.cmd = CmdQuery;
        f = mf + $urandom_range(0, int'((ml - mf) / 2));
        l = ml - $urandom_range(0, int'((ml - f) / 2));
        if ($urandom_range(0, 3) == 0) l = l + $urandom_range(1, int'(w * 2));
      end else begin
        f = pick_coord();
        l = f + $urandom_range(0, int'((sel % 3 == 0) ? w * BinBits * 2 : w * 4));
      end
      if (f > CoordMax) f = CoordMax;
      if (l > CoordMax) l = CoordMax;
      if (r.cmd == CmdMark && f <= l) begin
        mf = f;
        ml = l;
        have_mark = 1'b1;
      end
      r.first = f[CoordW-1:0];
      r.last = l[CoordW-1:0];
      send_item(r);
    end
  endtask

  stim_row_t directed_rows[] = '{
    '{CmdQuery, 31'd0, 31'd0, 1'b1, 1'b0, 1'b1},
    '{CmdMark, 31'd0, 31'd0, 1'b1, 1'b0, 1'b1},
    '{CmdQuery, 31'd0, 31'd99, 1'b0, 1'b0, 1'b0},
    '{CmdQuery, 31'd0, 31'd100, 1'b0, 1'b0, 1'b0},
    '{CmdMark, 31'd2999, 31'd2999, 1'b1, 1'b0, 1'b1},
    '{CmdMark, 31'd3000, 31'd8999, 1'b1, 1'b0, 1'b1},
    '{CmdQuery, 31'd2900, 31'd8999, 1'b0, 1'b0, 1'b0},
    '{CmdQuery, 31'd100, 31'd12000, 1'b0, 1'b0, 1'b0},
    '{CmdMark, 31'd500, 31'd400, 1'b1, 1'b0, 1'b1},
    '{CmdQuery, 31'd10, 31'd5, 1'b1, 1'b0, 1'b1},
    '{CmdMark, 31'd767900, 31'd767999, 1'b1, 1'b0, 1'b1},
    '{CmdQuery, 31'd767900, 31'd767999, 1'b0, 1'b0, 1'b0},
    '{CmdQuery, 31'd767800, 31'd767999, 1'b0, 1'b0, 1'b0},
    '{CmdQuery, 31'd768000, 31'd768000, 1'b1, 1'b0, 1'b0},
    '{CmdMark, 31'd0, 31'h7FFF_FFFF, 1'b1, 1'b0, 1'b0},
    '{CmdQuery, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b0, 1'b0},
    '{CmdMark, 31'd12000, 31'd20999, 1'b1, 1'b0, 1'b1},
    '{CmdQuery, 31'd12000, 31'd20999, 1'b0, 1'b0, 1'b0},
    '{CmdQuery, 31'd0, 31'd767999, 1'b0, 1'b0, 1'b0}
  };

  initial begin
    foreach (cov_bins[i]) cov_bins[i] = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (directed_rows[i]) send_item(directed_rows[i]);
    run_random(280);
    write_reg(RegOrigin, 1000);
    write_reg(RegWidth, 1);
    run_random(300);
    write_reg(RegOrigin, 12345);
    write_reg(RegWidth, 0);
    run_random(250);
    write_reg(RegOrigin, 5000000);
    write_reg(RegWidth, 65535);
    run_random(300);
    write_reg(RegOrigin, CoordMax);
    write_reg(RegWidth, 7);
    run_random(60);
    write_reg(RegOrigin, 0);
    write_reg(RegWidth, 1);
    run_random(100);
    quiet = 1'b1;
    run_random(150);
    in_valid_i <= 1'b0;
    wait (answer_q.size() == 0);
    repeat (400) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
